>>> rtl/bpa_pkg.sv
// Buddy page allocator: shared types, constants and index helpers.
// Used by bpa_ctrl and the top level; depends on nothing.
package bpa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int NUM_ORDERS = 11;
	localparam int FRAME_W    = 10;
	localparam int ORDER_W    = 4;
	localparam int ZBOUND_W   = 11;
	localparam int MAP_DEPTH  = 2 * NUM_PAGES;
	localparam int IDX_W      = 11;
	localparam logic [ORDER_W-1:0] TOP_ORDER = ORDER_W'(NUM_ORDERS - 1);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_SEED  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	localparam logic [1:0] ZONE_NONE = 2'd3;

	// config register indexes
	localparam logic REG_ZONE_ONE = 1'b0;
	localparam logic REG_ZONE_TWO = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SPLIT,
		ST_MERGE_RD,
		ST_MERGE_CHK,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic             wdata;
	} ram_req_t;

	// bit position of block (f, k): blocks of order k follow those of lower orders
	function automatic logic [IDX_W-1:0] map_idx(input logic [FRAME_W-1:0] f,
			input logic [ORDER_W-1:0] k);
		logic [IDX_W:0] base;
		base = (IDX_W+1)'(MAP_DEPTH) - ((IDX_W+1)'(MAP_DEPTH) >> k);
		return IDX_W'(base + {{(IDX_W+1-FRAME_W){1'b0}}, f >> k});
	endfunction

	function automatic logic [1:0] zone_of(input logic [FRAME_W-1:0] f,
			input logic [ZBOUND_W-1:0] z1, input logic [ZBOUND_W-1:0] z2);
		logic [ZBOUND_W-1:0] fx;
		fx = {1'b0, f};
		if (fx < z1) return 2'd0;
		if (fx < z2) return 2'd1;
		return 2'd2;
	endfunction

endpackage

>>> rtl/bpa_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> rtl/bpa_ctrl.sv
// Allocator sequencer: clear pass, search/split, merge and mark over the free map.
// Depends on bpa_pkg; drives the map RAM through a ram_req_t bundle.
module bpa_ctrl import bpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [1:0]          zone,
	input  logic [ORDER_W-1:0]  order,
	input  logic [FRAME_W-1:0]  frame,
	input  logic [ZBOUND_W-1:0] z1,
	input  logic [ZBOUND_W-1:0] z2,
	input  logic                map_rdata,
	output ram_req_t            ram_req,
	output logic                busy,
	output logic                done,
	output logic                status,
	output logic [FRAME_W-1:0]  block_frame,
	output logic [ORDER_W-1:0]  block_order
);
	state_t              state_q, state_d;
	logic [1:0]          zone_q;
	logic [ORDER_W-1:0]  k_q, k_d, c_q, c_d, h_q, h_d;
	logic [FRAME_W-1:0]  f_q, f_d;
	logic [IDX_W-1:0]    clr_q;
	logic                res_set, res_status;
	logic [FRAME_W-1:0]  res_frame;
	logic [ORDER_W-1:0]  res_order;
	logic [FRAME_W:0]    g_next;
	logic [FRAME_W-1:0]  buddy, split_f, amask;
	logic [ORDER_W-1:0]  h_dec;
	logic                bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_d == ST_DONE);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		c_q <= c_d;
		h_q <= h_d;
		f_q <= f_d;
		if (state_q == ST_IDLE) begin
			zone_q <= zone;
		end
		if (res_set) begin
			status      <= res_status;
			block_frame <= res_frame;
			block_order <= res_order;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		c_d        = c_q;
		h_d        = h_q;
		f_d        = f_q;
		res_set    = 1'b0;
		res_status = 1'b1;
		res_frame  = '0;
		res_order  = '0;
		ram_req    = '0;
		g_next     = {1'b0, f_q} + ((FRAME_W+1)'(1) << c_q);
		buddy      = f_q ^ (FRAME_W'(1) << k_q);
		h_dec      = h_q - ORDER_W'(1);
		split_f    = f_q + (FRAME_W'(1) << h_dec);
		amask      = FRAME_W'({FRAME_W{1'b1}} << order);
		bad        = (order > TOP_ORDER) || (op == OP_RSVD) ||
		             (op == OP_ALLOC && zone == ZONE_NONE);
		unique case (state_q)
			ST_CLEAR: begin
				ram_req.we   = 1'b1;
				ram_req.addr = clr_q;
				if (clr_q == IDX_W'(MAP_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					k_d = order;
					c_d = order;
					h_d = order;
					if (bad) begin
						res_set = 1'b1;
						state_d = ST_DONE;
					end else if (op == OP_ALLOC) begin
						f_d     = '0;
						state_d = ST_SCAN_RD;
					end else begin
						f_d     = frame & amask;
						state_d = (op == OP_FREE) ? ST_MERGE_RD : ST_MARK;
					end
				end
			end
			ST_SCAN_RD: begin
				ram_req.addr = map_idx(f_q, c_q);
				state_d      = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				ram_req.addr = map_idx(f_q, c_q);
				if (map_rdata && zone_of(f_q, z1, z2) == zone_q) begin
					ram_req.we = 1'b1;   // take the block
					h_d        = c_q;
					state_d    = ST_SPLIT;
				end else if (g_next[FRAME_W]) begin
					if (c_q == TOP_ORDER) begin
						res_set = 1'b1;
						state_d = ST_DONE;
					end else begin
						c_d     = c_q + ORDER_W'(1);
						f_d     = '0;
						state_d = ST_SCAN_RD;
					end
				end else begin
					f_d     = g_next[FRAME_W-1:0];
					state_d = ST_SCAN_RD;
				end
			end
			ST_SPLIT: begin
				if (h_q > k_q) begin
					// free the upper half one order down
					ram_req.we    = 1'b1;
					ram_req.addr  = map_idx(split_f, h_dec);
					ram_req.wdata = 1'b1;
					h_d           = h_dec;
				end else begin
					res_set    = 1'b1;
					res_status = 1'b0;
					res_frame  = f_q;
					res_order  = k_q;
					state_d    = ST_DONE;
				end
			end
			ST_MERGE_RD: begin
				ram_req.addr = map_idx(buddy, k_q);
				state_d      = (k_q == TOP_ORDER) ? ST_MARK : ST_MERGE_CHK;
			end
			ST_MERGE_CHK: begin
				ram_req.addr = map_idx(buddy, k_q);
				if (map_rdata && zone_of(buddy, z1, z2) == zone_of(f_q, z1, z2)) begin
					ram_req.we = 1'b1;
					f_d        = f_q & buddy;
					k_d        = k_q + ORDER_W'(1);
					state_d    = ST_MERGE_RD;
				end else begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				ram_req.we    = 1'b1;
				ram_req.addr  = map_idx(f_q, k_q);
				ram_req.wdata = 1'b1;
				res_set       = 1'b1;
				res_status    = 1'b0;
				res_frame     = f_q;
				res_order     = k_q;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("no idle after done strobe");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_req.we) else $error("map write while idle");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> block_frame == '0 && block_order == '0)
		else $error("failed item carries a block");
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> block_order <= TOP_ORDER) else $error("order out of range");
endmodule

>>> rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: zone registers, sequencer and map RAM.
// Depends on bpa_pkg, bpa_ctrl and bpa_ram.
//
//  channel   handshake            payload
//  input     start & !busy        op, zone, order, frame
//  result    done (1 cycle)       status, block_frame, block_order
//  config    cfg_we               cfg_idx, cfg_wdata
//
// The free map holds one bit per block per order in a 2048x1 RAM; one access per cycle.
// After reset a clearing pass zeroes every map bit with busy high; config writes still land.
// Allocate: each map bit is read and checked, from the requested order up; on a hit one
// split step per order down, then a step posts the result. Free: each buddy is read and
// checked (read only at top order), then marked; seed: mark only. Rejected item: no work.
// The result is shown on done for one cycle; the receiver cannot stall it.
module buddy_page_allocator import bpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic [1:0]          zone,
	input  logic [ORDER_W-1:0]  order,
	input  logic [FRAME_W-1:0]  frame,
	output logic                done,
	output logic                status,
	output logic [FRAME_W-1:0]  block_frame,
	output logic [ORDER_W-1:0]  block_order,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [ZBOUND_W-1:0] cfg_wdata
);
	logic [ZBOUND_W-1:0] zone_one_q, zone_two_q;
	ram_req_t            ram_req;
	logic                map_rdata;

	// zone bounds: frame below zone_one -> zone 0, below zone_two -> zone 1, else 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_one_q <= '0;
			zone_two_q <= ZBOUND_W'(NUM_PAGES);
		end else if (cfg_we) begin
			if (cfg_idx == REG_ZONE_ONE) begin
				zone_one_q <= cfg_wdata;
			end else begin
				zone_two_q <= cfg_wdata;
			end
		end
	end

	bpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.zone        (zone),
		.order       (order),
		.frame       (frame),
		.z1          (zone_one_q),
		.z2          (zone_two_q),
		.map_rdata   (map_rdata),
		.ram_req     (ram_req),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.block_frame (block_frame),
		.block_order (block_order)
	);

	bpa_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (map_rdata)
	);
endmodule
